[hdl/prle_pkg.sv]
// Shared types, constants and helpers for the row run-length encoder.
`default_nettype none
package prle_pkg;

  localparam int MAX_RUN_DEFAULT = 255;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int COUNT_W = 8;
  localparam int PIXEL_W = 24;
  localparam int WIDTH_W = 16;

  // Configuration register indexes
  localparam logic CFG_ROW_WIDTH = 1'b0;
  localparam logic CFG_COLOR_MODE = 1'b1;

  // One run record as it leaves the block
  typedef struct packed {
    logic                row_end;
    logic                last_of_item;
    logic [COUNT_W-1:0]  run_count;
    logic [PIXEL_W-1:0]  pixel;     // red/gray [23:16], green [15:8], blue [7:0]
  } record_t;

  // Up to two records caused by one pixel
  typedef struct packed {
    logic    a_valid;   // run closed by a value change or full count
    record_t a_rec;
    logic    b_valid;   // run closed by the end of the row
    record_t b_rec;
  } entry_t;

  // Clear green and blue in gray mode
  function automatic logic [PIXEL_W-1:0] mask_pixel(input logic [PIXEL_W-1:0] pix,
                                                    input logic color_mode);
    logic [PIXEL_W-1:0] res;
    res = color_mode ? pix : {pix[PIXEL_W-1:PIXEL_W-8], {(PIXEL_W-8){1'b0}}};
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/prle_front.sv]
// Front part: accepts pixels, tracks the open run and the column, forms records.
`default_nettype none
module prle_front #(
  parameter int MAX_RUN = prle_pkg::MAX_RUN_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pix_valid,
  input  wire logic [prle_pkg::PIXEL_W-1:0] pix_data,   // {blue, green, red_or_gray}
  input  wire logic                         queue_full,
  output logic                              pix_ready,
  input  wire logic [prle_pkg::WIDTH_W-1:0] row_width,
  input  wire logic                         color_mode,
  output logic                              push,
  output prle_pkg::entry_t                  push_entry
);
  import prle_pkg::*;

  logic [COUNT_W-1:0] run_length;
  logic [PIXEL_W-1:0] run_pixel;
  logic [WIDTH_W-1:0] column_count;

  logic [PIXEL_W-1:0] px;
  logic               run_open;
  logic               changed;
  logic               start_new;
  logic [COUNT_W-1:0] len_after;
  logic [WIDTH_W-1:0] col_next;
  logic               row_done;
  logic               accept;

  assign pix_ready = !queue_full;
  assign accept = pix_valid && pix_ready;

  // Classify the incoming pixel against the open run
  always_comb begin
    px = mask_pixel({pix_data[7:0], pix_data[15:8], pix_data[23:16]}, color_mode);
    run_open = (run_length != '0);
    changed = run_open && ((px != run_pixel) || (run_length >= COUNT_W'(MAX_RUN)));
    start_new = !run_open || changed;
    len_after = start_new ? COUNT_W'(1) : run_length + COUNT_W'(1);
    col_next = column_count + WIDTH_W'(1);
    row_done = (col_next >= row_width) || (col_next == '0);
  end

  // Build the queue entry
  always_comb begin
    push_entry.a_valid = changed;
    push_entry.a_rec.row_end = 1'b0;
    push_entry.a_rec.last_of_item = !row_done;
    push_entry.a_rec.run_count = run_length;
    push_entry.a_rec.pixel = mask_pixel(run_pixel, color_mode);
    push_entry.b_valid = row_done;
    push_entry.b_rec.row_end = 1'b1;
    push_entry.b_rec.last_of_item = 1'b1;
    push_entry.b_rec.run_count = len_after;
    push_entry.b_rec.pixel = px;
    push = accept && (changed || row_done);
  end

  // Advance run and column state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= '0;
      run_pixel <= '0;
      column_count <= '0;
    end else if (accept) begin
      run_length <= row_done ? '0 : len_after;
      if (start_new) begin
        run_pixel <= px;
      end
      column_count <= row_done ? '0 : col_next;
    end
  end

endmodule
`default_nettype wire

[hdl/prle_queue.sv]
// Short queue of record entries between the front and back parts.
`default_nettype none
module prle_queue #(
  parameter int DEPTH = prle_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  prle_pkg::entry_t      push_entry,
  input  wire logic             pop,
  output prle_pkg::entry_t      head_entry,
  output logic                  full,
  output logic                  empty
);
  import prle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head_entry = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/prle_back.sv]
// Back part: unpacks queue entries into single records behind an output register.
`default_nettype none
module prle_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  prle_pkg::entry_t  head_entry,
  input  wire logic         empty,
  output logic              pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [31:0]       m_tdata,   // run_count, out_red_or_gray, out_green, out_blue
  output logic              m_tlast,   // row_end
  output logic              m_tuser    // last_of_item
);
  import prle_pkg::*;

  logic    second;     // first record of the head entry already sent
  logic    load;
  logic    take_a;
  record_t sel_rec;

  // Pick the next record of the head entry
  always_comb begin
    load = (!m_tvalid || m_tready) && !empty;
    take_a = head_entry.a_valid && !second;
    sel_rec = take_a ? head_entry.a_rec : head_entry.b_rec;
    pop = load && !(take_a && head_entry.b_valid);
  end

  // Hold the output register until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      second <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        second <= take_a && head_entry.b_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {sel_rec.pixel[7:0], sel_rec.pixel[15:8], sel_rec.pixel[23:16],
                  sel_rec.run_count};
      m_tlast <= sel_rec.row_end;
      m_tuser <= sel_rec.last_of_item;
    end
  end

endmodule
`default_nettype wire

[hdl/pix_rle_row_encoder.sv]
// Top level of the row-bounded run-length encoder.
//
// Pixels enter on the s_ stream (one pixel per transfer, raster order) and
// run records leave on the m_ stream: tdata carries count and pixel value,
// tlast marks the last record of a row, tuser the last record that one pixel
// caused. The user must write row_width and color_mode through cfg_we/
// cfg_index/cfg_data only while the block is idle; the block does not enforce it.
// A pixel is taken every cycle while the entry queue has room. The front
// part classifies it in the accepting cycle and, when it closes a record,
// writes the queue at that edge; the output register then loads the entry
// from the queue head once it is empty or being read, and raises m_tvalid.
// Throughput is one pixel per cycle while the queue has room, set by the
// combinational run compare and the column counter; a pixel that closes two
// records at a row end needs two output transfers, which the queue absorbs.
// Reset clears the open run, the column count and the queue, and sets
// row_width to 1 and color mode to RGB. When the receiver stalls, the output
// register holds its record, the queue fills, and s_tready drops.
`default_nettype none
module pix_rle_row_encoder #(
  parameter int MAX_RUN = prle_pkg::MAX_RUN_DEFAULT,
  parameter int QUEUE_DEPTH = prle_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [prle_pkg::PIXEL_W-1:0]  s_tdata,   // red_or_gray, green, blue
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [31:0]                        m_tdata,   // run_count, out_red_or_gray,
                                                        // out_green, out_blue
  output logic                               m_tlast,   // row_end
  output logic                               m_tuser,   // last_of_item
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [prle_pkg::WIDTH_W-1:0]  cfg_data
);
  import prle_pkg::*;

  logic [WIDTH_W-1:0] row_width;
  logic               color_mode;
  logic               push;
  entry_t             push_entry;
  entry_t             head_entry;
  logic               full;
  logic               empty;
  logic               pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= WIDTH_W'(1);
      color_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_WIDTH:  row_width <= cfg_data;
        CFG_COLOR_MODE: color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  prle_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pix_valid(s_tvalid),
    .pix_data(s_tdata),
    .queue_full(full),
    .pix_ready(s_tready),
    .row_width(row_width),
    .color_mode(color_mode),
    .push(push),
    .push_entry(push_entry)
  );

  prle_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head_entry(head_entry),
    .full(full),
    .empty(empty)
  );

  prle_back u_back (
    .clk(clk),
    .rst(rst),
    .head_entry(head_entry),
    .empty(empty),
    .pop(pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for pix_rle_row_encoder: predicts run records per pixel and checks the record stream.
`timescale 1ns / 1ps
module tb;
  import prle_pkg::*;

  // One expected or observed run record
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
    logic       row_end;
    logic       item_end;
  } run_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [PIXEL_W-1:0]   s_tdata = '0;     // red_or_gray, green, blue
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;          // run_count, out_red_or_gray, out_green, out_blue
  logic                 m_tlast;          // row_end
  logic                 m_tuser;          // last_of_item
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_ROW_WIDTH;
  logic [WIDTH_W-1:0]   cfg_data = '0;

  // Encoder state as predicted
  logic [15:0] row_width_q = 16'd1;
  logic        color_mode_q = 1'b1;
  logic [7:0]  run_len = 8'd0;
  logic [23:0] run_pix = 24'd0;
  logic [15:0] col_cnt = 16'd0;
  run_rec_t    pending_runs[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatch_cnt = 0;

  run_rec_t got_rec;
  run_rec_t want_rec;
  logic     want_ok;

  pix_rle_row_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Build the record for a closing run; green and blue read as zero in gray mode
  function automatic run_rec_t close_run(input logic [7:0] len, input logic [23:0] pix,
                                         input logic at_row_end);
    run_rec_t r;
    r.count    = len;
    r.red      = pix[23:16];
    r.grn      = color_mode_q ? pix[15:8] : 8'h00;
    r.blu      = color_mode_q ? pix[7:0] : 8'h00;
    r.row_end  = at_row_end;
    r.item_end = 1'b0;
    return r;
  endfunction

  // Advance the run state by one pixel and queue the records it closes
  function automatic void encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    logic [23:0] px;
    run_rec_t    recs[2];
    int          n;
    n  = 0;
    px = {r, color_mode_q ? g : 8'h00, color_mode_q ? b : 8'h00};
    if (run_len == 8'd0) begin
      run_len = 8'd1;
      run_pix = px;
    end else if (px != run_pix || run_len >= MAX_RUN_DEFAULT) begin
      recs[n] = close_run(run_len, run_pix, 1'b0);
      n++;
      run_len = 8'd1;
      run_pix = px;
    end else begin
      run_len = run_len + 8'd1;
    end
    col_cnt = col_cnt + 16'd1;
    if (col_cnt >= row_width_q || col_cnt == 16'd0) begin
      recs[n] = close_run(run_len, run_pix, 1'b1);
      n++;
      run_len = 8'd0;
      col_cnt = 16'd0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) recs[i].item_end = 1'b1;
      pending_runs.push_back(recs[i]);
    end
  endfunction

  // Offer one pixel, hold it until the transfer, then predict
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_pixel(r, g, b);
  endtask

  // Drop valid and wait until every expected record has left the block
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ROW_WIDTH) row_width_q = val;
    else color_mode_q = val[0];
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3, 4, 5, 6: return 16'($urandom_range(16, 3));
      7: return 16'($urandom_range(300, 17));
      8: return 16'hFFFF;
      default: return 16'($urandom_range(1000, 256));
    endcase
  endfunction

  // Send runs of random pixels; gray repeats vary the ignored fields,
  // RGB repeats sometimes flip one bit to break a run by a hair
  task automatic send_runs(input int n_items);
    logic [7:0] r, g, b;
    int reps, sent;
    sent = 0;
    while (sent < n_items) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: reps = 1;
        6, 7, 8: reps = $urandom_range(12, 2);
        default: reps = $urandom_range(40, 13);
      endcase
      repeat (reps) begin
        if (!color_mode_q && $urandom_range(1) == 1)
          send_pixel(r, 8'($urandom), 8'($urandom));
        else if (color_mode_q && $urandom_range(9) == 0)
          send_pixel(r, g ^ (8'h01 << $urandom_range(7)), b);
        else
          send_pixel(r, g, b);
        sent++;
      end
    end
  endtask

  // Reset values: width 1, RGB, so every pixel is a one-pixel row
  task automatic test_reset_state();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h12, 8'h34, 8'h56);
    wait_idle();
  endtask

  // Runs inside a row, and a row end that closes two records at once
  task automatic test_row_end_records();
    write_reg(CFG_ROW_WIDTH, 16'd4);
    write_reg(CFG_COLOR_MODE, 16'd1);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    wait_idle();
  endtask

  // Switch to gray while an RGB run with nonzero green/blue is open
  task automatic test_mode_switch_in_run();
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'h01, 8'h02, 8'h03);
    wait_idle();
    write_reg(CFG_COLOR_MODE, 16'hFFFE);
    send_pixel(8'h01, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h77, 8'h88);
    wait_idle();
  endtask

  // Width zero acts as one; lowering the width mid-row ends the row next pixel
  task automatic test_width_edges();
    write_reg(CFG_ROW_WIDTH, 16'd0);
    send_pixel(8'h00, 8'h11, 8'h22);
    send_pixel(8'hFF, 8'h33, 8'h44);
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 16'hFFFF);
    repeat (3) send_pixel(8'h80, 8'($urandom), 8'($urandom));
    wait_idle();
    write_reg(CFG_ROW_WIDTH, 16'd2);
    send_pixel(8'h80, 8'h00, 8'h00);
    wait_idle();
  endtask

  // A run that hits the count limit exactly on a row end, then keeps going
  task automatic test_full_run();
    logic [7:0] r, g, b;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    write_reg(CFG_ROW_WIDTH, 16'd256);
    write_reg(CFG_COLOR_MODE, 16'd1);
    repeat (300) send_pixel(r, g, b);
    wait_idle();
  endtask

  // Random rows under one idling pattern, reconfiguring between segments
  task automatic test_random_rows(input int src_pct, input int sink_pct);
    logic [15:0] mode_val;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (4) begin
      wait_idle();
      mode_val    = 16'($urandom);
      mode_val[0] = $urandom_range(1);
      write_reg(CFG_ROW_WIDTH, pick_width());
      write_reg(CFG_COLOR_MODE, mode_val);
      send_runs(50);
    end
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while pixels keep coming
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_reg(CFG_ROW_WIDTH, 16'd7);
    write_reg(CFG_COLOR_MODE, 16'd1);
    hold_req++;
    send_runs(50);
    wait_idle();
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= 300;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each record transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_rec.count    = m_tdata[7:0];
      got_rec.red      = m_tdata[15:8];
      got_rec.grn      = m_tdata[23:16];
      got_rec.blu      = m_tdata[31:24];
      got_rec.row_end  = m_tlast;
      got_rec.item_end = m_tuser;
      want_ok = (pending_runs.size() != 0);
      if (want_ok) want_rec = pending_runs.pop_front();
      else want_rec = '0;
      if (!want_ok || got_rec != want_rec) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: record mismatch (expected %s): ", $realtime,
                   want_ok ? "one" : "none",
                   "exp count=%0d pix=%h %h %h row_end=%b last=%b, ",
                   want_rec.count, want_rec.red, want_rec.grn, want_rec.blu,
                   want_rec.row_end, want_rec.item_end,
                   "got count=%0d pix=%h %h %h row_end=%b last=%b",
                   got_rec.count, got_rec.red, got_rec.grn, got_rec.blu,
                   got_rec.row_end, got_rec.item_end);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_row_end_records();
    test_mode_switch_in_run();
    test_width_edges();
    test_full_run();
    test_random_rows(27, 88);
    test_random_rows(88, 27);
    test_random_rows(0, 0);
    test_backpressure();
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0 && pending_runs.size() == 0)
      $display("PASS pix_rle_row_encoder");
    else
      $display("FAIL pix_rle_row_encoder");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL pix_rle_row_encoder");
    $finish;
  end

endmodule
